// ----- rtl/bat_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bat_pkg: shared definitions for the breakpoint address table
// Table geometry, derived widths, command and status codes, state encoding.
// ----------------------------------------------------------------------------
package bat_pkg;

    // The bucket count is a power of two, so an address splits into its
    // bucket (low bits) and its tag (high bits) by bit slicing.
    localparam int BUCKETS    = 256;
    localparam int WAYS       = 4;
    localparam int ENTRIES    = BUCKETS * WAYS;

    localparam int ADDR_W     = 64;
    localparam int BUCKET_W   = $clog2(BUCKETS);
    localparam int WAY_W      = (WAYS > 1) ? $clog2(WAYS) : 1;
    localparam int SLOT_AW    = $clog2(ENTRIES);
    localparam int TAG_W      = ADDR_W - BUCKET_W;
    localparam int SLOT_FLD_W = 10;

    typedef enum logic [1:0] {
        CMD_CREATE = 2'd0,
        CMD_FIND   = 2'd1,
        CMD_DELETE = 2'd2
    } cmd_t;

    typedef enum logic [1:0] {
        ST_DONE      = 2'd0,
        ST_PRESENT   = 2'd1,
        ST_NOT_FOUND = 2'd2,
        ST_FULL      = 2'd3
    } status_t;

    typedef enum logic [2:0] {
        S_CLEAR,
        S_IDLE,
        S_START,
        S_LOOK,
        S_ACT
    } state_t;

    // Keeps the low bits of a table slot for the result field.
    function automatic logic [SLOT_FLD_W-1:0] slot_field(input logic [SLOT_AW-1:0] s);
        logic [SLOT_AW+SLOT_FLD_W-1:0] wide;
        wide = {{SLOT_FLD_W{1'b0}}, s};
        return wide[SLOT_FLD_W-1:0];
    endfunction

endpackage

// ----- rtl/bat_ram.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bat_ram: generic simple dual-port RAM
// One write port and one read port; read data is registered on read enable.
// ----------------------------------------------------------------------------
module bat_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end

endmodule

// ----- rtl/breakpoint_address_table.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// breakpoint_address_table: set-associative table of breakpoint addresses
// Create, find and delete requests against BUCKETS buckets of WAYS ways each.
// ----------------------------------------------------------------------------
// Sequence: a request beat is taken in idle, the start state reads the
// valid row, a lookup state per way follows, and the act state commits once
// the result register has room; one request is in work at a time. The single
// tag comparator checks one way per cycle from the tag RAM read port.
// Reset: after rst_n the valid RAM is swept one bucket row per cycle, over
// all BUCKETS rows, while req_stall is held high; the table then reads empty.
// ----------------------------------------------------------------------------
module breakpoint_address_table (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             req_valid,
    output logic                             req_stall,
    input  logic [1:0]                       cmd,
    input  logic [bat_pkg::ADDR_W-1:0]       address,
    output logic                             rsp_valid,
    input  logic                             rsp_stall,
    output logic [1:0]                       status,
    output logic                             hit,
    output logic [bat_pkg::SLOT_FLD_W-1:0]   slot
);

    // ------------------------------------------------------------------
    // Sequencer and control registers (reset).
    // ------------------------------------------------------------------
    bat_pkg::state_t                   state_reg, state_next;
    logic                              rsp_valid_reg, rsp_valid_next;
    logic [bat_pkg::BUCKET_W-1:0]      clr_row_reg, clr_row_next;
    logic [bat_pkg::WAY_W-1:0]         way_reg, way_next;

    // ------------------------------------------------------------------
    // Request payload and working registers (no reset).
    // ------------------------------------------------------------------
    bat_pkg::cmd_t                     cmd_reg, cmd_next;
    logic [bat_pkg::TAG_W-1:0]         tag_reg, tag_next;
    logic [bat_pkg::BUCKET_W-1:0]      bucket_reg, bucket_next;
    logic                              found_reg, found_next;
    logic                              free_reg, free_next;
    logic [bat_pkg::WAY_W-1:0]         match_way_reg, match_way_next;
    logic [bat_pkg::WAY_W-1:0]         free_way_reg, free_way_next;
    bat_pkg::status_t                  status_reg, status_next;
    logic                              hit_reg, hit_next;
    logic [bat_pkg::SLOT_FLD_W-1:0]    slot_reg, slot_next;

    // ------------------------------------------------------------------
    // RAM ports. The valid RAM holds one row of WAYS bits per bucket; the
    // tag RAM holds one tag per slot and is read one way per cycle.
    // ------------------------------------------------------------------
    logic                              vld_we, vld_re;
    logic [bat_pkg::BUCKET_W-1:0]      vld_waddr;
    logic [bat_pkg::WAYS-1:0]          vld_wdata, vld_rdata;
    logic                              tag_we, tag_re;
    logic [bat_pkg::SLOT_AW-1:0]       tag_waddr, tag_raddr;
    logic [bat_pkg::TAG_W-1:0]         tag_rdata;

    // Slot arithmetic and handshake terms.
    logic [bat_pkg::SLOT_AW-1:0]       base_slot;
    logic [bat_pkg::SLOT_AW-1:0]       match_slot, free_slot;
    logic                              req_beat, rsp_free;
    logic                              tag_eq;
    logic [bat_pkg::WAYS-1:0]          row_new;

    bat_ram #(
        .WIDTH (bat_pkg::WAYS),
        .DEPTH (bat_pkg::BUCKETS)
    ) u_valid_ram (
        .clk   (clk),
        .we    (vld_we),
        .waddr (vld_waddr),
        .wdata (vld_wdata),
        .re    (vld_re),
        .raddr (bucket_reg),
        .rdata (vld_rdata)
    );

    bat_ram #(
        .WIDTH (bat_pkg::TAG_W),
        .DEPTH (bat_pkg::ENTRIES)
    ) u_tag_ram (
        .clk   (clk),
        .we    (tag_we),
        .waddr (tag_waddr),
        .wdata (tag_reg),
        .re    (tag_re),
        .raddr (tag_raddr),
        .rdata (tag_rdata)
    );

    assign req_stall = (state_reg != bat_pkg::S_IDLE);
    assign req_beat  = req_valid && !req_stall;
    // The result register can take a new beat when empty or when it drains now.
    assign rsp_free  = !rsp_valid_reg || !rsp_stall;

    assign rsp_valid = rsp_valid_reg;
    assign status    = status_reg;
    assign hit       = hit_reg;
    assign slot      = slot_reg;

    // Slot numbers are bucket * WAYS + way.
    assign base_slot  = bat_pkg::SLOT_AW'(bucket_reg) * bat_pkg::SLOT_AW'(bat_pkg::WAYS);
    assign match_slot = base_slot + bat_pkg::SLOT_AW'(match_way_reg);
    assign free_slot  = base_slot + bat_pkg::SLOT_AW'(free_way_reg);

    // The shared comparator: the tag read last cycle against the request tag.
    assign tag_eq = (tag_rdata == tag_reg);

    always_comb
    begin
        state_next     = state_reg;
        rsp_valid_next = rsp_valid_reg && rsp_stall;
        clr_row_next   = clr_row_reg;
        way_next       = way_reg;

        cmd_next       = cmd_reg;
        tag_next       = tag_reg;
        bucket_next    = bucket_reg;
        found_next     = found_reg;
        free_next      = free_reg;
        match_way_next = match_way_reg;
        free_way_next  = free_way_reg;
        status_next    = status_reg;
        hit_next       = hit_reg;
        slot_next      = slot_reg;

        vld_we    = 1'b0;
        vld_re    = 1'b0;
        vld_waddr = bucket_reg;
        vld_wdata = '0;
        tag_we    = 1'b0;
        tag_re    = 1'b0;
        tag_waddr = free_slot;
        tag_raddr = base_slot + bat_pkg::SLOT_AW'(way_reg);
        row_new   = vld_rdata;

        case (state_reg)
            bat_pkg::S_CLEAR:
            begin
                vld_we       = 1'b1;
                vld_waddr    = clr_row_reg;
                vld_wdata    = '0;
                clr_row_next = clr_row_reg + 1'b1;
                if (clr_row_reg == bat_pkg::BUCKET_W'(bat_pkg::BUCKETS - 1))
                begin
                    state_next = bat_pkg::S_IDLE;
                end
            end

            bat_pkg::S_IDLE:
            begin
                if (req_beat)
                begin
                    cmd_next    = bat_pkg::cmd_t'(cmd);
                    bucket_next = address[bat_pkg::BUCKET_W-1:0];
                    tag_next    = address[bat_pkg::ADDR_W-1:bat_pkg::BUCKET_W];
                    state_next  = bat_pkg::S_START;
                end
            end

            bat_pkg::S_START:
            begin
                // Fetch the bucket's valid row and the tag of way zero.
                vld_re     = 1'b1;
                tag_re     = 1'b1;
                tag_raddr  = base_slot;
                way_next   = '0;
                found_next = 1'b0;
                free_next  = 1'b0;
                state_next = bat_pkg::S_LOOK;
            end

            bat_pkg::S_LOOK:
            begin
                if (vld_rdata[way_reg])
                begin
                    if (!found_reg && tag_eq)
                    begin
                        found_next     = 1'b1;
                        match_way_next = way_reg;
                    end
                end
                else if (!free_reg)
                begin
                    free_next     = 1'b1;
                    free_way_next = way_reg;
                end

                if (way_reg == bat_pkg::WAY_W'(bat_pkg::WAYS - 1))
                begin
                    state_next = bat_pkg::S_ACT;
                end
                else
                begin
                    way_next  = way_reg + 1'b1;
                    tag_re    = 1'b1;
                    tag_raddr = base_slot + bat_pkg::SLOT_AW'(way_next);
                end
            end

            bat_pkg::S_ACT:
            begin
                // Commit the table change and the result together, once the
                // result register has room.
                if (rsp_free)
                begin
                    rsp_valid_next = 1'b1;
                    state_next     = bat_pkg::S_IDLE;
                    case (cmd_reg)
                        bat_pkg::CMD_CREATE:
                        begin
                            if (found_reg)
                            begin
                                status_next = bat_pkg::ST_PRESENT;
                                hit_next    = 1'b1;
                                slot_next   = bat_pkg::slot_field(match_slot);
                            end
                            else if (free_reg)
                            begin
                                row_new[free_way_reg] = 1'b1;
                                vld_we      = 1'b1;
                                vld_wdata   = row_new;
                                tag_we      = 1'b1;
                                tag_waddr   = free_slot;
                                status_next = bat_pkg::ST_DONE;
                                hit_next    = 1'b0;
                                slot_next   = bat_pkg::slot_field(free_slot);
                            end
                            else
                            begin
                                status_next = bat_pkg::ST_FULL;
                                hit_next    = 1'b0;
                                slot_next   = '0;
                            end
                        end

                        bat_pkg::CMD_DELETE:
                        begin
                            if (found_reg)
                            begin
                                row_new[match_way_reg] = 1'b0;
                                vld_we      = 1'b1;
                                vld_wdata   = row_new;
                                status_next = bat_pkg::ST_DONE;
                                hit_next    = 1'b1;
                                slot_next   = bat_pkg::slot_field(match_slot);
                            end
                            else
                            begin
                                status_next = bat_pkg::ST_NOT_FOUND;
                                hit_next    = 1'b0;
                                slot_next   = '0;
                            end
                        end

                        // Find, and the unused code, which behaves as find.
                        default:
                        begin
                            if (found_reg)
                            begin
                                status_next = bat_pkg::ST_DONE;
                                hit_next    = 1'b1;
                                slot_next   = bat_pkg::slot_field(match_slot);
                            end
                            else
                            begin
                                status_next = bat_pkg::ST_NOT_FOUND;
                                hit_next    = 1'b0;
                                slot_next   = '0;
                            end
                        end
                    endcase
                end
            end

            default:
            begin
                state_next = bat_pkg::S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= bat_pkg::S_CLEAR;
            rsp_valid_reg <= 1'b0;
            clr_row_reg   <= '0;
            way_reg       <= '0;
        end
        else
        begin
            state_reg     <= state_next;
            rsp_valid_reg <= rsp_valid_next;
            clr_row_reg   <= clr_row_next;
            way_reg       <= way_next;
        end
    end

    always_ff @(posedge clk)
    begin
        cmd_reg       <= cmd_next;
        tag_reg       <= tag_next;
        bucket_reg    <= bucket_next;
        found_reg     <= found_next;
        free_reg      <= free_next;
        match_way_reg <= match_way_next;
        free_way_reg  <= free_way_next;
        status_reg    <= status_next;
        hit_reg       <= hit_next;
        slot_reg      <= slot_next;
    end

endmodule

// ----- bench/bat_response_checker.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bat_response_checker: predicts and checks breakpoint table responses
// Watches the request and response channels. It keeps its own copy of the
// table, computes the expected status, hit and slot for every request beat,
// and compares each response beat against the oldest expected response.
// ----------------------------------------------------------------------------
module bat_response_checker (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           req_valid,
    input  logic                           req_stall,
    input  logic [1:0]                     cmd,
    input  logic [bat_pkg::ADDR_W-1:0]     address,
    input  logic                           rsp_valid,
    input  logic                           rsp_stall,
    input  logic [1:0]                     status,
    input  logic                           hit,
    input  logic [bat_pkg::SLOT_FLD_W-1:0] slot,
    output int                             mismatch_count,
    output int                             replies_owed
);

    typedef struct {
        bat_pkg::status_t               status;
        logic                           hit;
        logic [bat_pkg::SLOT_FLD_W-1:0] slot;
    } reply_t;

    reply_t                      owed_replies[$];
    logic                        entry_live[bat_pkg::ENTRIES];
    logic [bat_pkg::TAG_W-1:0]   entry_key[bat_pkg::ENTRIES];

    // Looks the address up in its bucket and applies the command to the
    // local table copy. Codes other than create and delete act as find.
    function automatic reply_t lookup_update(input logic [1:0] op,
                                             input logic [bat_pkg::ADDR_W-1:0] addr);
        reply_t                       r;
        logic [bat_pkg::ADDR_W-1:0]   bucket;
        logic [bat_pkg::ADDR_W-1:0]   key;
        int                           base;
        int                           w;
        int                           s;
        int                           match_s;
        int                           free_s;
        bit                           found;
        bit                           have_free;
        bucket    = addr % bat_pkg::BUCKETS;
        key       = addr / bat_pkg::BUCKETS;
        base      = int'(bucket) * bat_pkg::WAYS;
        found     = 1'b0;
        have_free = 1'b0;
        match_s   = 0;
        free_s    = 0;
        for (w = 0; w < bat_pkg::WAYS; w++)
        begin
            s = base + w;
            if (s < bat_pkg::ENTRIES)
            begin
                if (entry_live[bat_pkg::SLOT_AW'(s)])
                begin
                    if (!found && entry_key[bat_pkg::SLOT_AW'(s)] == key[bat_pkg::TAG_W-1:0])
                    begin
                        found   = 1'b1;
                        match_s = s;
                    end
                end
                else if (!have_free)
                begin
                    have_free = 1'b1;
                    free_s    = s;
                end
            end
        end

        r.status = bat_pkg::ST_NOT_FOUND;
        r.hit    = 1'b0;
        r.slot   = '0;
        case (op)
            bat_pkg::CMD_CREATE:
            begin
                if (found)
                begin
                    r.status = bat_pkg::ST_PRESENT;
                    r.hit    = 1'b1;
                    r.slot   = bat_pkg::SLOT_FLD_W'(match_s);
                end
                else if (have_free)
                begin
                    entry_live[bat_pkg::SLOT_AW'(free_s)] = 1'b1;
                    entry_key[bat_pkg::SLOT_AW'(free_s)]  = key[bat_pkg::TAG_W-1:0];
                    r.status = bat_pkg::ST_DONE;
                    r.slot   = bat_pkg::SLOT_FLD_W'(free_s);
                end
                else
                begin
                    r.status = bat_pkg::ST_FULL;
                end
            end
            bat_pkg::CMD_DELETE:
            begin
                if (found)
                begin
                    entry_live[bat_pkg::SLOT_AW'(match_s)] = 1'b0;
                    r.status = bat_pkg::ST_DONE;
                    r.hit    = 1'b1;
                    r.slot   = bat_pkg::SLOT_FLD_W'(match_s);
                end
            end
            default:
            begin
                if (found)
                begin
                    r.status = bat_pkg::ST_DONE;
                    r.hit    = 1'b1;
                    r.slot   = bat_pkg::SLOT_FLD_W'(match_s);
                end
            end
        endcase
        return r;
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        reply_t want;
        int     bad;
        if (!rst_n)
        begin
            entry_live = '{default: 1'b0};
            owed_replies.delete();
            replies_owed <= 0;
        end
        else
        begin
            bad = 0;
            if (rsp_valid && !rsp_stall)
            begin
                if (owed_replies.size() == 0)
                begin
                    $error("response beat with nothing outstanding: status %0d hit %0d slot %0d",
                           status, hit, slot);
                    bad++;
                end
                else
                begin
                    want = owed_replies.pop_front();
                    if (status !== want.status)
                    begin
                        $error("status: expected %0d, actual %0d", want.status, status);
                        bad++;
                    end
                    if (hit !== want.hit)
                    begin
                        $error("hit: expected %0d, actual %0d", want.hit, hit);
                        bad++;
                    end
                    if (slot !== want.slot)
                    begin
                        $error("slot: expected %0d, actual %0d", want.slot, slot);
                        bad++;
                    end
                end
            end
            if (req_valid && !req_stall)
                owed_replies.push_back(lookup_update(cmd, address));
            mismatch_count <= mismatch_count + bad;
            replies_owed   <= owed_replies.size();
        end
    end

endmodule

// ----- bench/tb_breakpoint_address_table.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_breakpoint_address_table: testbench for the breakpoint address table
// Drives create, find and delete requests, first a directed sequence that
// walks one bucket through fill, overflow and deletes, then random traffic
// focused on a few crowded buckets. A checker beside the block predicts and
// compares every response; this module makes stimulus and gives the verdict.
// ----------------------------------------------------------------------------
module tb_breakpoint_address_table;

    // Unused command code; the block decodes it as a find.
    localparam logic [1:0] CMD_SPARE = 2'd3;

    localparam int RANDOM_ITEMS = 1800;
    // Long receiver hold-off, far longer than one request takes.
    localparam int LONG_HOLD    = 300;
    // Generous cap: reset sweep plus every request at its slowest, several times.
    localparam int CYCLE_LIMIT  = 400000;

    typedef enum int {
        STALL_NONE,
        STALL_RANDOM,
        STALL_PERIODIC,
        STALL_HEAVY
    } stall_mode_t;

    logic                           clk;
    logic                           rst_n;
    logic                           req_valid;
    logic                           req_stall;
    logic [1:0]                     cmd;
    logic [bat_pkg::ADDR_W-1:0]     address;
    logic                           rsp_valid;
    logic                           rsp_stall;
    logic [1:0]                     status;
    logic                           hit;
    logic [bat_pkg::SLOT_FLD_W-1:0] slot;

    int                    mismatch_count;
    int                    replies_owed;
    int                    burst_left;
    int                    cycle_count;
    bit                    long_hold_go;

    breakpoint_address_table uut (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req_valid),
        .req_stall (req_stall),
        .cmd       (cmd),
        .address   (address),
        .rsp_valid (rsp_valid),
        .rsp_stall (rsp_stall),
        .status    (status),
        .hit       (hit),
        .slot      (slot)
    );

    bat_response_checker u_rsp_check (
        .clk            (clk),
        .rst_n          (rst_n),
        .req_valid      (req_valid),
        .req_stall      (req_stall),
        .cmd            (cmd),
        .address        (address),
        .rsp_valid      (rsp_valid),
        .rsp_stall      (rsp_stall),
        .status         (status),
        .hit            (hit),
        .slot           (slot),
        .mismatch_count (mismatch_count),
        .replies_owed   (replies_owed)
    );

    initial
    begin
        clk = 1'b0;
        forever #10 clk = ~clk;
    end

    // Offers one request beat and holds it until the block takes it. The
    // sender runs in bursts: when a burst is used up, valid drops for a random
    // gap and a new burst length is drawn. A burst length of zero gives an
    // isolated beat, a long one gives a stretch with no idling at all.
    task automatic offer(input logic [1:0] op, input logic [bat_pkg::ADDR_W-1:0] addr);
        req_valid <= 1'b1;
        cmd       <= op;
        address   <= addr;
        @(posedge clk);
        while (req_stall)
            @(posedge clk);
        if (burst_left == 0)
        begin
            req_valid <= 1'b0;
            repeat ($urandom_range(1, 12)) @(posedge clk);
            burst_left = $urandom_range(0, 40);
        end
        else
        begin
            burst_left--;
        end
    endtask

    // Drops valid and waits until every response owed has come back. The
    // first edge lets the checker count a beat taken in this very step.
    task automatic drain_replies();
        req_valid <= 1'b0;
        @(posedge clk);
        while (replies_owed != 0)
            @(posedge clk);
    endtask

    // Receiver side. It switches among stall patterns of random span, and
    // once the random traffic starts it holds the response channel off for a
    // long stretch while the sender keeps offering, so the block backs up
    // and stalls its own request channel.
    initial
    begin : rsp_side
        stall_mode_t mode;
        int          span;
        int          k;
        bit          held;
        rsp_stall = 1'b0;
        held      = 1'b0;
        @(posedge clk);
        forever
        begin
            if (!held && long_hold_go)
            begin
                held = 1'b1;
                rsp_stall <= 1'b1;
                repeat (LONG_HOLD) @(posedge clk);
            end
            mode = stall_mode_t'($urandom_range(0, 3));
            span = $urandom_range(8, 64);
            for (k = 0; k < span; k++)
            begin
                case (mode)
                    STALL_NONE:     rsp_stall <= 1'b0;
                    STALL_RANDOM:   rsp_stall <= ($urandom_range(0, 1) == 1);
                    STALL_PERIODIC: rsp_stall <= (k % 3 == 2);
                    default:        rsp_stall <= ($urandom_range(0, 3) != 0);
                endcase
                @(posedge clk);
            end
        end
    end

    // Watchdog: a run that has not finished by the cap is a failure.
    initial
    begin : watchdog
        cycle_count = 0;
        while (cycle_count < CYCLE_LIMIT)
        begin
            @(posedge clk);
            cycle_count++;
        end
        $display("Mismatches found");
        $finish;
    end

    initial
    begin : stimulus
        logic [bat_pkg::ADDR_W-1:0] tag_pool[8];
        logic [bat_pkg::ADDR_W-1:0] hot_bucket[4];
        logic [bat_pkg::ADDR_W-1:0] key;
        logic [bat_pkg::ADDR_W-1:0] bkt;
        logic [1:0]                 op;
        int                         n;
        int                         pick;

        rst_n        = 1'b0;
        req_valid    = 1'b0;
        cmd          = bat_pkg::CMD_CREATE;
        address      = '0;
        burst_left   = 0;
        long_hold_go = 1'b0;
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;

        // Directed part. Bucket 0 is filled through all four ways, overflows,
        // then loses its head entry; the later ways must survive that delete.
        // The freed head way is then the lowest free way and is reused.
        offer(bat_pkg::CMD_CREATE, 64'h0000_0000_0000_0000);  // new entry, way 0
        offer(bat_pkg::CMD_FIND,   64'h0000_0000_0000_0000);  // hit
        offer(bat_pkg::CMD_CREATE, 64'h0000_0000_0000_0000);  // already present
        offer(bat_pkg::CMD_CREATE, 64'h0000_0000_0000_0100);  // way 1
        offer(bat_pkg::CMD_CREATE, 64'hFFFF_FFFF_FFFF_FF00);  // largest tag, way 2
        offer(bat_pkg::CMD_CREATE, 64'h5555_5555_5555_5500);  // way 3, bucket now full
        offer(bat_pkg::CMD_CREATE, 64'hAAAA_AAAA_AAAA_AA00);  // bucket full
        offer(bat_pkg::CMD_FIND,   64'hAAAA_AAAA_AAAA_AA00);  // miss
        offer(bat_pkg::CMD_DELETE, 64'h0000_0000_0000_0000);  // delete of the bucket head
        offer(bat_pkg::CMD_FIND,   64'h0000_0000_0000_0100);  // rest of the bucket stays
        offer(bat_pkg::CMD_FIND,   64'hFFFF_FFFF_FFFF_FF00);
        offer(bat_pkg::CMD_CREATE, 64'hAAAA_AAAA_AAAA_AA00);  // takes the freed way 0
        offer(bat_pkg::CMD_DELETE, 64'h0000_0000_0000_0100);  // frees way 1
        offer(bat_pkg::CMD_DELETE, 64'h0000_0000_0000_0100);  // delete miss
        offer(CMD_SPARE,           64'hFFFF_FFFF_FFFF_FF00);  // spare code, hit
        offer(CMD_SPARE,           64'h0000_0000_0000_0100);  // spare code, miss
        // Last bucket: the highest slot numbers.
        offer(bat_pkg::CMD_CREATE, 64'hFFFF_FFFF_FFFF_FFFF);
        offer(bat_pkg::CMD_FIND,   64'hFFFF_FFFF_FFFF_FFFF);
        offer(bat_pkg::CMD_CREATE, 64'h8000_0000_0000_00FF);
        offer(bat_pkg::CMD_DELETE, 64'hFFFF_FFFF_FFFF_FFFF);
        offer(bat_pkg::CMD_CREATE, 64'h7FFF_FFFF_FFFF_FFFF);  // reuses the freed way
        offer(bat_pkg::CMD_FIND,   64'h0000_0000_0000_00FF);  // tag zero, miss
        offer(bat_pkg::CMD_DELETE, 64'h5555_5555_5555_5500);

        // The sender pauses until the directed responses are all back.
        drain_replies();

        // Random part. Most addresses fall into four crowded buckets with a
        // small pool of tags, so entries collide, buckets fill and deletes
        // find their targets. The rest take a random bucket or a random tag.
        tag_pool[0] = '0;
        tag_pool[1] = {bat_pkg::ADDR_W{1'b1}} / bat_pkg::BUCKETS;
        for (n = 2; n < 8; n++)
            tag_pool[3'(n)] = {$urandom, $urandom} / bat_pkg::BUCKETS;
        hot_bucket[0] = '0;
        hot_bucket[1] = bat_pkg::ADDR_W'(bat_pkg::BUCKETS - 1);
        hot_bucket[2] = bat_pkg::ADDR_W'($urandom_range(0, bat_pkg::BUCKETS - 1));
        hot_bucket[3] = bat_pkg::ADDR_W'($urandom_range(0, bat_pkg::BUCKETS - 1));

        long_hold_go = 1'b1;
        for (n = 0; n < RANDOM_ITEMS; n++)
        begin
            pick = $urandom_range(0, 99);
            if (pick < 40)
                op = bat_pkg::CMD_CREATE;
            else if (pick < 65)
                op = bat_pkg::CMD_FIND;
            else if (pick < 95)
                op = bat_pkg::CMD_DELETE;
            else
                op = CMD_SPARE;

            if ($urandom_range(0, 9) < 8)
                bkt = hot_bucket[2'($urandom_range(0, 3))];
            else
                bkt = bat_pkg::ADDR_W'($urandom_range(0, bat_pkg::BUCKETS - 1));
            if ($urandom_range(0, 19) < 17)
                key = tag_pool[3'($urandom_range(0, 7))];
            else
                key = {$urandom, $urandom} / bat_pkg::BUCKETS;

            offer(op, key * bat_pkg::BUCKETS + bkt);

            // A second full drain halfway through the random traffic.
            if (n == RANDOM_ITEMS / 2)
                drain_replies();
        end

        drain_replies();
        // Room for a stray late beat to show up before the verdict.
        repeat (4 * (bat_pkg::WAYS + 3)) @(posedge clk);

        if (mismatch_count == 0)
            $display("No mismatches found");
        else
            $display("Mismatches found");
        $finish;
    end

endmodule
